[rtl/core/ssmk_pkg.sv]
// Shared types and constants for the subset-sum modulo-k reachability block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package ssmk_pkg;

  localparam int AMOUNT_W  = 16;
  localparam int VALUE_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int TOTAL_W   = 26;
  localparam int MODULUS_W = 6;

  localparam int DEF_MAX_MODULUS = 63;
  localparam int DEF_MAX_ITEMS   = 1024;
  localparam int DEF_AMOUNT_BITS = 16;

  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic                last_item;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] answer_count;
    logic               empty_res;
    logic               last_result;
  } result_t;

  // Status from the serial remainder unit to the sequencer.
  typedef struct packed {
    logic                 done;
    logic [MODULUS_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

[rtl/core/subset_sum_mod_k_reachability.sv]
// Top level of the subset-sum modulo-k reachability block: sequencer, state, output register.
// Depends on ssmk_pkg and ssmk_rem_unit.
//
//   channel   signals                         direction  payload
//   item      item_valid / item_stall / item  in         ssmk_pkg::item_t
//   result    result_valid / result_stall     out        ssmk_pkg::result_t
//   cfg       cfg_valid / cfg_ready / cfg_data in        modulus, 6 bits
//
// An item goes through the bit-serial remainder unit (amount mod k), then the reachable set
// is rotated by amount mod k places, one place per rotate-by-one step. A last item then adds
// a multiply step, a count walk over the values 0..k and an emit walk over them (a single
// result for an empty answer), each emit step held while a result is stalled.
// item_stall is high in reset and from acceptance until the item and any answer walk are done.
// Reset is synchronous and needs no clearing pass.
`default_nettype none

module subset_sum_mod_k_reachability #(
  parameter int MAX_MODULUS = ssmk_pkg::DEF_MAX_MODULUS,
  parameter int MAX_ITEMS   = ssmk_pkg::DEF_MAX_ITEMS,
  parameter int AMOUNT_BITS = ssmk_pkg::DEF_AMOUNT_BITS
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           item_valid,
  output logic                          item_stall,
  input  ssmk_pkg::item_t               item,
  output logic                          result_valid,
  input  wire                           result_stall,
  output ssmk_pkg::result_t             result,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [ssmk_pkg::MODULUS_W-1:0] cfg_data
);
  import ssmk_pkg::*;

  localparam int AMT_KEEP = (AMOUNT_BITS < AMOUNT_W) ? AMOUNT_BITS : AMOUNT_W;
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
  localparam int PROD_W   = CNT_W + MODULUS_W;
  localparam int CMP_W    = (TOTAL_W > PROD_W) ? TOTAL_W : PROD_W;
  localparam int SW       = $clog2(MAX_MODULUS);
  localparam int IW       = $clog2(MAX_MODULUS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_ROT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]             state;
  logic [MODULUS_W-1:0]   modulus;
  logic [MAX_MODULUS-1:0] reach;
  logic [MAX_MODULUS-1:0] rot;
  logic [TOTAL_W-1:0]     total;
  logic [CNT_W-1:0]       count;
  logic                   last;
  logic [MODULUS_W-1:0]   rcnt;
  logic [PROD_W-1:0]      prod;
  logic [IW-1:0]          idx;
  logic [COUNT_W-1:0]     n;
  logic [COUNT_W-1:0]     emitted;

  logic [MODULUS_W-1:0]   k;
  logic [MODULUS_W-1:0]   k_m1;
  logic [MAX_MODULUS-1:0] km;
  logic [MAX_MODULUS-1:0] rot_next;
  logic [MAX_MODULUS:0]   reach_pad;
  logic                   accept;
  logic                   slot_free;
  logic                   zero_ok;
  logic                   total_ge_k;
  logic                   qual;
  logic                   idx_is_k;
  logic [TOTAL_W:0]       sum;
  logic [AMOUNT_W-1:0]    amt_eff;
  div_res_t               div_res;

  assign accept     = item_valid && !item_stall;
  assign item_stall = rst || (state != S_IDLE);
  assign cfg_ready  = !rst;
  assign slot_free  = !result_valid || !result_stall;

  // Effective modulus: zero counts as one, values above the maximum are clamped.
  always_comb begin
    if (modulus == '0) begin
      k = MODULUS_W'(1);
    end else if (modulus > MODULUS_W'(MAX_MODULUS)) begin
      k = MODULUS_W'(MAX_MODULUS);
    end else begin
      k = modulus;
    end
    k_m1 = k - MODULUS_W'(1);
  end

  // Mask of live remainders, and a rotate by one place within the low k bits.
  always_comb begin
    for (int b = 0; b < MAX_MODULUS; b++) begin
      km[b] = (MODULUS_W'(b) < k);
    end
    rot_next[0] = rot[k_m1[SW-1:0]];
    for (int b = 1; b < MAX_MODULUS; b++) begin
      rot_next[b] = km[b] ? rot[b-1] : 1'b0;
    end
  end

  assign amt_eff = AMOUNT_W'(item.amount[AMT_KEEP-1:0]);
  assign sum     = {1'b0, total} + (TOTAL_W+1)'(amt_eff);

  assign zero_ok    = CMP_W'(total) <= CMP_W'(prod);
  assign total_ge_k = total >= TOTAL_W'(k);
  assign reach_pad  = {1'b0, reach};
  assign idx_is_k   = (MODULUS_W'(idx) == k);

  // Does the value under the walk index belong to the answer?
  always_comb begin
    if (idx == '0) begin
      qual = zero_ok;
    end else if (idx_is_k) begin
      qual = total_ge_k;
    end else begin
      qual = reach_pad[idx];
    end
  end

  ssmk_rem_unit #(
    .DIV_BITS (AMT_KEEP)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (item.amount[AMT_KEEP-1:0]),
    .divisor  (k),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_W'(MAX_MODULUS);
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      reach        <= MAX_MODULUS'(1);
      total        <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            reach <= reach & km;
            total <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
            if (count < CNT_W'(MAX_ITEMS)) begin
              count <= count + CNT_W'(1);
            end
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_res.done) begin
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (rcnt == '0) begin
            reach <= reach | rot;
            state <= last ? S_MUL : S_IDLE;
          end
        end
        S_MUL: begin
          state <= S_CNT;
        end
        S_CNT: begin
          if (idx_is_k) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (n == '0 || qual) begin
              result_valid <= 1'b1;
            end
            if (n == '0 || idx_is_k) begin
              reach <= MAX_MODULUS'(1);
              total <= '0;
              count <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rot  <= reach & km;
          last <= item.last_item;
        end
      end
      S_MOD: begin
        rcnt <= div_res.rem;
      end
      S_ROT: begin
        if (rcnt != '0) begin
          rot  <= rot_next;
          rcnt <= rcnt - MODULUS_W'(1);
        end
      end
      S_MUL: begin
        prod <= PROD_W'({{MODULUS_W{1'b0}}, count - CNT_W'(1)} * {{CNT_W{1'b0}}, k});
        idx  <= '0;
        n    <= '0;
      end
      S_CNT: begin
        if (qual) begin
          n <= n + COUNT_W'(1);
        end
        if (idx_is_k) begin
          idx     <= '0;
          emitted <= '0;
        end else begin
          idx <= idx + IW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          if (n == '0) begin
            result.value        <= '0;
            result.answer_count <= '0;
            result.empty_res    <= 1'b1;
            result.last_result  <= 1'b1;
          end else if (qual) begin
            result.value        <= VALUE_W'(idx);
            result.answer_count <= n;
            result.empty_res    <= 1'b0;
            result.last_result  <= (emitted + COUNT_W'(1) == n);
            emitted             <= emitted + COUNT_W'(1);
          end
          idx <= idx + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ssmk_rem_unit.sv]
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on ssmk_pkg.
`default_nettype none

module ssmk_rem_unit #(
  parameter int DIV_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire [DIV_BITS-1:0]               dividend,
  input  wire [ssmk_pkg::MODULUS_W-1:0]    divisor,
  output ssmk_pkg::div_res_t               res
);
  import ssmk_pkg::*;

  localparam int CW = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0]  shreg;
  logic [MODULUS_W-1:0] rem;
  logic [CW-1:0]        cnt;
  logic                 done;

  logic [MODULUS_W:0]   trial;
  logic                 ge;
  logic [MODULUS_W-1:0] rem_next;

  // Shift in the next dividend bit, then one compare and subtract.
  always_comb begin
    trial    = {rem, shreg[DIV_BITS-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? MODULUS_W'(trial - {1'b0, divisor}) : trial[MODULUS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DIV_BITS);
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (cnt != '0) begin
      shreg <= shreg << 1;
      rem   <= rem_next;
    end
  end

  assign res.done = done;
  assign res.rem  = rem;

endmodule

`default_nettype wire

[rtl/core/ssmk_checker.sv]
// Port-level checker for subset_sum_mod_k_reachability, attached by the bind below.
// Depends on ssmk_pkg.
`default_nettype none

module ssmk_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           item_valid,
  input wire                           item_stall,
  input ssmk_pkg::item_t               item,
  input wire                           result_valid,
  input wire                           result_stall,
  input ssmk_pkg::result_t             result,
  input wire                           cfg_valid,
  input wire                           cfg_ready,
  input wire [ssmk_pkg::MODULUS_W-1:0] cfg_data
);
  import ssmk_pkg::*;

  // A stalled result transaction keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The block works on one item at a time, so it stalls right after a transaction.
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item taken while a previous item is in progress");

  // An empty answer is a single closing result with a zero count.
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.empty_res |-> result.last_result && result.answer_count == '0)
    else $error("malformed empty result");

  // A non-empty result carries a nonzero count of at most 64.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.empty_res |->
      result.answer_count != '0 && result.answer_count <= COUNT_W'(64))
    else $error("bad answer count");

endmodule

bind subset_sum_mod_k_reachability ssmk_checker u_ssmk_checker (.*);

`default_nettype wire
